// File: rtl/core/keyframe_track_sampler_assert.svh
// Assertion helpers shared by the sampler RTL.
// Each helper expects clk and rst_n in scope.
`ifndef KEYFRAME_TRACK_SAMPLER_ASSERT_SVH
`define KEYFRAME_TRACK_SAMPLER_ASSERT_SVH

// Same-cycle implication.
`define KTS_ASSERT_IMPLY(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("sampler check failed: same-cycle implication");

// Next-cycle implication.
`define KTS_ASSERT_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("sampler check failed: next-cycle implication");

`endif

// File: rtl/core/kts_pkg.sv
`default_nettype none

package kts_pkg;

    // Field widths.
    localparam int TIME_W     = 24;
    localparam int COMP_W     = 24;
    localparam int CFG_DATA_W = 7;
    localparam int ENTRY_W    = TIME_W + 4 * COMP_W;

    // Request operations.
    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    // Track kinds.
    localparam logic KIND_VECTOR = 1'b0;
    localparam logic KIND_QUAT   = 1'b1;

    // Configuration register indexes.
    localparam logic [0:0] REG_KEY_COUNT  = 1'b0;
    localparam logic [0:0] REG_TRACK_KIND = 1'b1;

    // Blend factor in Q1.16: one and zero.
    localparam logic [16:0] F_ONE  = 17'd65536;
    localparam logic [16:0] F_ZERO = 17'd0;

    typedef logic signed [COMP_W-1:0] comp_t;

    typedef struct packed {
        logic              operation;
        logic [5:0]        key_index;
        logic [TIME_W-1:0] time_req;
        comp_t             comp_x;
        comp_t             comp_y;
        comp_t             comp_z;
        comp_t             comp_w;
    } req_t;

    typedef struct packed {
        comp_t out_x;
        comp_t out_y;
        comp_t out_z;
        comp_t out_w;
        logic  out_of_range;
    } res_t;

endpackage

`default_nettype wire

// File: rtl/core/keyframe_track_sampler.sv
`default_nettype none

// Keyframe track sampler. A load request writes one key (Q16.8 time and four
// Q11.12 components) into a key memory of MAX_KEYS entries with one write and
// one read port and returns nothing. A sample request scans the key times one
// per cycle for the first interval whose end lies beyond the sample time,
// reads both keys, forms the Q1.16 blend factor (with a bit-serial divider
// when the time lies inside the interval) and blends. One request is in work
// at a time. In quaternion mode a two-key sample runs three normalizations,
// each a square root and, for a nonzero norm, four divisions on the shared
// divider. A result waits in the output register while the next request is
// taken. Keys are undefined until loaded; sample only keys that were written.

`include "keyframe_track_sampler_assert.svh"

module keyframe_track_sampler #(
    parameter int MAX_KEYS = 64
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             req_valid,
    output logic                             req_stall,
    input  kts_pkg::req_t                    req,
    output logic                             res_valid,
    input  logic                             res_stall,
    output kts_pkg::res_t                    res,
    input  logic                             wr_en,
    input  logic [0:0]                       wr_index,
    input  logic [kts_pkg::CFG_DATA_W-1:0]   wr_data
);
    import kts_pkg::*;

    localparam int AW = $clog2(MAX_KEYS);
    localparam int CW = $clog2(MAX_KEYS + 1);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SRCH  = 4'd1;
    localparam logic [3:0] S_RDA   = 4'd2;
    localparam logic [3:0] S_RDB   = 4'd3;
    localparam logic [3:0] S_ONE   = 4'd4;
    localparam logic [3:0] S_MODE  = 4'd5;
    localparam logic [3:0] S_VEC   = 4'd6;
    localparam logic [3:0] S_SQ    = 4'd7;
    localparam logic [3:0] S_SQRT  = 4'd8;
    localparam logic [3:0] S_UNIT  = 4'd9;
    localparam logic [3:0] S_DIV   = 4'd10;
    localparam logic [3:0] S_DOT   = 4'd11;
    localparam logic [3:0] S_BLEND = 4'd12;
    localparam logic [3:0] S_OUT   = 4'd13;

    localparam logic [1:0] PH_A   = 2'd0;
    localparam logic [1:0] PH_B   = 2'd1;
    localparam logic [1:0] PH_MIX = 2'd2;

    // Rounds a Q.16 value to an integer, half away from zero.
    function automatic logic signed [63:0] round16(input logic signed [63:0] v);
        logic [63:0] m;
        m = v[63] ? 64'(-v) : 64'(v);
        m = (m + 64'd32768) >> 16;
        return v[63] ? -$signed(m) : $signed(m);
    endfunction

    // Control registers.
    logic [3:0]            state_reg, state_next;
    logic [6:0]            key_count_reg, key_count_next;
    logic                  track_kind_reg, track_kind_next;
    logic                  res_valid_reg, res_valid_next;

    // Work registers.
    res_t                  res_reg, res_next;
    logic [TIME_W-1:0]     t_reg, t_next;
    logic [TIME_W-1:0]     t0_reg, t0_next;
    logic [CW-1:0]         n_reg, n_next;
    logic [AW-1:0]         k_reg, k_next;
    logic [AW-1:0]         i_reg, i_next;
    logic                  found_reg, found_next;
    logic                  flag_reg, flag_next;
    logic [16:0]           f_reg, f_next;
    comp_t                 a_reg [4];
    comp_t                 a_next [4];
    comp_t                 b_reg [4];
    comp_t                 b_next [4];
    comp_t                 resc_reg [4];
    comp_t                 resc_next [4];
    logic signed [31:0]    ua_reg [4];
    logic signed [31:0]    ua_next [4];
    logic signed [31:0]    ub_reg [4];
    logic signed [31:0]    ub_next [4];
    logic signed [31:0]    mix_reg [4];
    logic signed [31:0]    mix_next [4];
    logic [1:0]            phase_reg, phase_next;
    logic [1:0]            c_reg, c_next;
    logic [1:0]            sub_reg, sub_next;
    logic [5:0]            cnt_reg, cnt_next;
    logic signed [63:0]    mul_reg, mul_next;
    logic signed [63:0]    acc_reg, acc_next;
    logic [63:0]           sqv_reg, sqv_next;
    logic [63:0]           sqres_reg, sqres_next;
    logic [31:0]           norm_reg, norm_next;
    logic                  dotneg_reg, dotneg_next;
    logic [31:0]           div_rem_reg, div_rem_next;
    logic [31:0]           div_d_reg, div_d_next;
    logic [63:0]           div_num_reg, div_num_next;
    logic [31:0]           div_q_reg, div_q_next;
    logic                  div_unit_reg, div_unit_next;

    // Memory port.
    logic [ENTRY_W-1:0]    mem [MAX_KEYS];
    logic [ENTRY_W-1:0]    rdata_reg;
    logic                  mem_we;
    logic [AW-1:0]         mem_waddr;
    logic [AW-1:0]         mem_raddr;
    logic [ENTRY_W-1:0]    mem_wdata;

    // Datapath helpers.
    logic [TIME_W-1:0]     rd_time;
    comp_t                 rd_comp [4];
    logic signed [31:0]    cur [4];
    logic [31:0]           cur_mag [4];
    logic [CW-1:0]         n_clamp;
    logic                  slot_ok;
    logic signed [32:0]    mul_a, mul_b;
    logic signed [65:0]    mul_p;
    logic [32:0]           div_r2;
    logic                  div_ge;
    logic [31:0]           div_q_step;
    logic [63:0]           sq_bit, sq_try, sq_sum;
    logic [63:0]           u_m, u_half, u_num;
    logic signed [63:0]    blend_r, vec_r, dot_sum;
    logic signed [32:0]    bk;
    logic signed [24:0]    vec_d;
    logic                  hit, last;
    logic                  unit_store;
    logic signed [31:0]    unit_val;
    logic                  srch_k_ok;

    // Key memory: one write, one registered read per cycle. Only one request
    // is in work, so a load never overlaps a read whose data is used.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= mem[mem_raddr];
    end

    // Split the read entry into time and components.
    always_comb
    begin
        rd_time = rdata_reg[ENTRY_W-1 -: TIME_W];
        for (int k = 0; k < 4; k++)
        begin
            rd_comp[k] = comp_t'(rdata_reg[4*COMP_W-1-k*COMP_W -: COMP_W]);
        end
    end

    // Vector that the current normalization works on, and its magnitudes.
    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            case (phase_reg)
                PH_A:    cur[k] = 32'(a_reg[k]);
                PH_B:    cur[k] = 32'(b_reg[k]);
                default: cur[k] = mix_reg[k];
            endcase
            cur_mag[k] = cur[k][31] ? 32'(-cur[k]) : 32'(cur[k]);
        end
    end

    // Key count limited to the table, with zero taken as one.
    always_comb
    begin
        if (32'(key_count_reg) > 32'(MAX_KEYS))
        begin
            n_clamp = CW'(MAX_KEYS);
        end
        else if (key_count_reg == 7'd0)
        begin
            n_clamp = CW'(1);
        end
        else
        begin
            n_clamp = CW'(key_count_reg);
        end
    end

    assign slot_ok = 32'(req.key_index) < 32'(MAX_KEYS);

    // Shared multiplier, registered before any use.
    assign mul_p = mul_a * mul_b;

    // One restoring division step.
    assign div_r2     = {div_rem_reg, div_num_reg[63]};
    assign div_ge     = div_r2 >= {1'b0, div_d_reg};
    assign div_q_step = {div_q_reg[30:0], div_ge};

    // One square-root step.
    assign sq_bit = 64'd1 << {cnt_reg[4:0], 1'b0};
    assign sq_try = sqres_reg + sq_bit;
    assign sq_sum = 64'(acc_reg + mul_reg);

    // Rounded numerator for a normalization division.
    assign u_m    = {32'd0, cur_mag[c_reg]};
    assign u_half = {33'd0, norm_reg[31:1]};
    assign u_num  = (phase_reg == PH_MIX) ? ((u_m << 12) + u_half) : ((u_m << 37) + u_half);

    assign blend_r = round16(acc_reg + mul_reg);
    assign vec_r   = 64'(a_reg[c_reg]) + round16(mul_reg);
    assign dot_sum = acc_reg + mul_reg;
    assign bk      = dotneg_reg ? -33'(ub_reg[c_reg]) : 33'(ub_reg[c_reg]);
    assign vec_d   = 25'(b_reg[c_reg]) - 25'(a_reg[c_reg]);

    // Search compare on the time just read.
    assign hit  = t_reg < rd_time;
    assign last = CW'(k_reg) == (n_reg - CW'(2));

    // Sequencer and datapath.
    always_comb
    begin
        state_next      = state_reg;
        key_count_next  = key_count_reg;
        track_kind_next = track_kind_reg;
        res_valid_next  = res_valid_reg;
        res_next        = res_reg;
        t_next          = t_reg;
        t0_next         = t0_reg;
        n_next          = n_reg;
        k_next          = k_reg;
        i_next          = i_reg;
        found_next      = found_reg;
        flag_next       = flag_reg;
        f_next          = f_reg;
        a_next          = a_reg;
        b_next          = b_reg;
        resc_next       = resc_reg;
        ua_next         = ua_reg;
        ub_next         = ub_reg;
        mix_next        = mix_reg;
        phase_next      = phase_reg;
        c_next          = c_reg;
        sub_next        = sub_reg;
        cnt_next        = cnt_reg;
        acc_next        = acc_reg;
        sqv_next        = sqv_reg;
        sqres_next      = sqres_reg;
        norm_next       = norm_reg;
        dotneg_next     = dotneg_reg;
        div_rem_next    = div_rem_reg;
        div_d_next      = div_d_reg;
        div_num_next    = div_num_reg;
        div_q_next      = div_q_reg;
        div_unit_next   = div_unit_reg;
        mem_we          = 1'b0;
        mem_waddr       = AW'(req.key_index);
        mem_wdata       = {req.time_req, req.comp_x, req.comp_y, req.comp_z, req.comp_w};
        mem_raddr       = '0;
        mul_a           = '0;
        mul_b           = '0;
        unit_store      = 1'b0;
        unit_val        = '0;

        // Configuration writes.
        if (wr_en)
        begin
            case (wr_index)
                REG_KEY_COUNT:  key_count_next = wr_data[6:0];
                REG_TRACK_KIND: track_kind_next = wr_data[0];
                default:        key_count_next = key_count_reg;
            endcase
        end

        // Output register drains when taken.
        if (res_valid_reg && !res_stall)
        begin
            res_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    t_next = req.time_req;
                    if (req.operation == OP_LOAD)
                    begin
                        mem_we = slot_ok;
                    end
                    else
                    begin
                        n_next = n_clamp;
                        if (n_clamp == CW'(1))
                        begin
                            state_next = S_ONE;
                        end
                        else
                        begin
                            mem_raddr  = AW'(1);
                            k_next     = '0;
                            state_next = S_SRCH;
                        end
                    end
                end
            end

            // One key time per cycle; the next read is issued ahead.
            S_SRCH:
            begin
                if (hit || last)
                begin
                    i_next     = k_reg;
                    found_next = hit;
                    mem_raddr  = k_reg;
                    state_next = S_RDA;
                end
                else
                begin
                    k_next    = k_reg + AW'(1);
                    mem_raddr = k_reg + AW'(2);
                end
            end

            S_RDA:
            begin
                t0_next    = rd_time;
                a_next     = rd_comp;
                mem_raddr  = i_reg + AW'(1);
                state_next = S_RDB;
            end

            // Second key is in; pick the factor or start its division.
            S_RDB:
            begin
                b_next = rd_comp;
                if (!found_reg)
                begin
                    f_next     = F_ONE;
                    flag_next  = 1'b1;
                    state_next = S_MODE;
                end
                else if (t_reg < t0_reg)
                begin
                    f_next     = F_ZERO;
                    flag_next  = 1'b1;
                    state_next = S_MODE;
                end
                else
                begin
                    flag_next     = 1'b0;
                    div_rem_next  = 32'(t_reg - t0_reg);
                    div_d_next    = 32'(rd_time - t0_reg);
                    div_num_next  = '0;
                    div_q_next    = '0;
                    div_unit_next = 1'b0;
                    cnt_next      = 6'd15;
                    state_next    = S_DIV;
                end
            end

            S_ONE:
            begin
                resc_next = rd_comp;
                if (track_kind_reg == KIND_VECTOR)
                begin
                    resc_next[3] = '0;
                end
                flag_next  = 1'b0;
                state_next = S_OUT;
            end

            S_MODE:
            begin
                c_next   = '0;
                sub_next = '0;
                if (track_kind_reg == KIND_VECTOR)
                begin
                    state_next = S_VEC;
                end
                else
                begin
                    phase_next = PH_A;
                    acc_next   = '0;
                    cnt_next   = '0;
                    state_next = S_SQ;
                end
            end

            // Linear blend, one component at a time: multiply, then add and store.
            S_VEC:
            begin
                if (sub_reg == 2'd0)
                begin
                    mul_a    = 33'(vec_d);
                    mul_b    = $signed({16'd0, f_reg});
                    sub_next = 2'd1;
                end
                else
                begin
                    resc_next[c_reg] = vec_r[COMP_W-1:0];
                    sub_next         = 2'd0;
                    if (c_reg == 2'd2)
                    begin
                        resc_next[3] = '0;
                        state_next   = S_OUT;
                    end
                    else
                    begin
                        c_next = c_reg + 2'd1;
                    end
                end
            end

            // Sum of squares, one component per cycle.
            S_SQ:
            begin
                if (cnt_reg < 6'd4)
                begin
                    mul_a = $signed({1'b0, cur_mag[cnt_reg[1:0]]});
                    mul_b = $signed({1'b0, cur_mag[cnt_reg[1:0]]});
                end
                if (cnt_reg != 6'd0)
                begin
                    acc_next = acc_reg + mul_reg;
                end
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'd4)
                begin
                    sqv_next   = (phase_reg == PH_MIX) ? sq_sum : (sq_sum << 14);
                    sqres_next = '0;
                    cnt_next   = 6'd31;
                    state_next = S_SQRT;
                end
            end

            // Floor square root, two radicand bits per cycle.
            S_SQRT:
            begin
                if (sqv_reg >= sq_try)
                begin
                    sqv_next   = sqv_reg - sq_try;
                    sqres_next = (sqres_reg >> 1) + sq_bit;
                end
                else
                begin
                    sqres_next = sqres_reg >> 1;
                end
                cnt_next = cnt_reg - 6'd1;
                if (cnt_reg == 6'd0)
                begin
                    norm_next  = sqres_next[31:0];
                    c_next     = '0;
                    state_next = S_UNIT;
                end
            end

            // Set up the division of one component by the norm, or store zero for a zero norm.
            S_UNIT:
            begin
                if (norm_reg == 32'd0)
                begin
                    unit_store = 1'b1;
                end
                else
                begin
                    div_unit_next = 1'b1;
                    div_q_next    = '0;
                    div_d_next    = norm_reg;
                    if (phase_reg == PH_MIX)
                    begin
                        div_rem_next = u_num[44:13];
                        div_num_next = {u_num[12:0], 51'd0};
                        cnt_next     = 6'd12;
                    end
                    else
                    begin
                        div_rem_next = u_num[62:31];
                        div_num_next = {u_num[30:0], 33'd0};
                        cnt_next     = 6'd30;
                    end
                    state_next = S_DIV;
                end
            end

            // Restoring division, one quotient bit per cycle.
            S_DIV:
            begin
                div_rem_next = div_ge ? 32'(div_r2 - {1'b0, div_d_reg}) : div_r2[31:0];
                div_q_next   = div_q_step;
                div_num_next = div_num_reg << 1;
                cnt_next     = cnt_reg - 6'd1;
                if (cnt_reg == 6'd0)
                begin
                    if (div_unit_reg)
                    begin
                        unit_store = 1'b1;
                        unit_val   = cur[c_reg][31] ? -$signed(div_q_step)
                                                    : $signed(div_q_step);
                    end
                    else
                    begin
                        f_next     = div_q_step[16:0];
                        state_next = S_MODE;
                    end
                end
            end

            // Dot product of both unit keys; only its sign is kept.
            S_DOT:
            begin
                if (cnt_reg < 6'd4)
                begin
                    mul_a = 33'(ua_reg[cnt_reg[1:0]]);
                    mul_b = 33'(ub_reg[cnt_reg[1:0]]);
                end
                if (cnt_reg != 6'd0)
                begin
                    acc_next = acc_reg + mul_reg;
                end
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'd4)
                begin
                    dotneg_next = dot_sum[63];
                    c_next      = '0;
                    sub_next    = '0;
                    state_next  = S_BLEND;
                end
            end

            // Weighted sum of both unit keys, component by component.
            S_BLEND:
            begin
                case (sub_reg)
                    2'd0:
                    begin
                        mul_a    = 33'(ua_reg[c_reg]);
                        mul_b    = $signed({16'd0, 17'(F_ONE - f_reg)});
                        sub_next = 2'd1;
                    end
                    2'd1:
                    begin
                        acc_next = mul_reg;
                        mul_a    = bk;
                        mul_b    = $signed({16'd0, f_reg});
                        sub_next = 2'd2;
                    end
                    default:
                    begin
                        mix_next[c_reg] = blend_r[31:0];
                        sub_next        = 2'd0;
                        if (c_reg == 2'd3)
                        begin
                            phase_next = PH_MIX;
                            acc_next   = '0;
                            cnt_next   = '0;
                            c_next     = '0;
                            state_next = S_SQ;
                        end
                        else
                        begin
                            c_next = c_reg + 2'd1;
                        end
                    end
                endcase
            end

            // Hand the result to the output register once it is free or being taken.
            S_OUT:
            begin
                if (!res_valid_reg || !res_stall)
                begin
                    res_valid_next        = 1'b1;
                    res_next.out_x        = resc_reg[0];
                    res_next.out_y        = resc_reg[1];
                    res_next.out_z        = resc_reg[2];
                    res_next.out_w        = resc_reg[3];
                    res_next.out_of_range = flag_reg;
                    state_next            = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Store one normalized component and move on.
        if (unit_store)
        begin
            case (phase_reg)
                PH_A:    ua_next[c_reg] = unit_val;
                PH_B:    ub_next[c_reg] = unit_val;
                default: resc_next[c_reg] = comp_t'(unit_val[COMP_W-1:0]);
            endcase
            if (c_reg == 2'd3)
            begin
                c_next   = '0;
                acc_next = '0;
                cnt_next = '0;
                case (phase_reg)
                    PH_A:
                    begin
                        phase_next = PH_B;
                        state_next = S_SQ;
                    end
                    PH_B:    state_next = S_DOT;
                    default: state_next = S_OUT;
                endcase
            end
            else
            begin
                c_next     = c_reg + 2'd1;
                state_next = S_UNIT;
            end
        end
    end

    assign mul_next = $signed(mul_p[63:0]);

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            key_count_reg  <= 7'd1;
            track_kind_reg <= KIND_VECTOR;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            key_count_reg  <= key_count_next;
            track_kind_reg <= track_kind_next;
            res_valid_reg  <= res_valid_next;
        end
    end

    // Work registers.
    always_ff @(posedge clk)
    begin
        res_reg      <= res_next;
        t_reg        <= t_next;
        t0_reg       <= t0_next;
        n_reg        <= n_next;
        k_reg        <= k_next;
        i_reg        <= i_next;
        found_reg    <= found_next;
        flag_reg     <= flag_next;
        f_reg        <= f_next;
        a_reg        <= a_next;
        b_reg        <= b_next;
        resc_reg     <= resc_next;
        ua_reg       <= ua_next;
        ub_reg       <= ub_next;
        mix_reg      <= mix_next;
        phase_reg    <= phase_next;
        c_reg        <= c_next;
        sub_reg      <= sub_next;
        cnt_reg      <= cnt_next;
        mul_reg      <= mul_next;
        acc_reg      <= acc_next;
        sqv_reg      <= sqv_next;
        sqres_reg    <= sqres_next;
        norm_reg     <= norm_next;
        dotneg_reg   <= dotneg_next;
        div_rem_reg  <= div_rem_next;
        div_d_reg    <= div_d_next;
        div_num_reg  <= div_num_next;
        div_q_reg    <= div_q_next;
        div_unit_reg <= div_unit_next;
    end

    assign req_stall = (state_reg != S_IDLE);
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    // Checks.
    assign srch_k_ok = CW'(k_reg) <= (n_reg - CW'(2));

    `KTS_ASSERT_IMPLY(a_srch_bound, state_reg == S_SRCH, srch_k_ok)
    `KTS_ASSERT_IMPLY(a_div_rem, state_reg == S_DIV, div_rem_reg < div_d_reg)
    `KTS_ASSERT_NEXT(a_out_free, (state_reg == S_OUT) && !res_valid_reg, res_valid_reg && (state_reg == S_IDLE))
    `KTS_ASSERT_NEXT(a_load_quiet, req_valid && !req_stall && (req.operation == OP_LOAD), state_reg == S_IDLE)

endmodule

`default_nettype wire

// File: tb/tb_keyframe_track_sampler.sv
`default_nettype none

module tb_keyframe_track_sampler;
    timeunit 1ns;
    timeprecision 1ps;

    import kts_pkg::*;

    localparam int NUM_SLOTS     = 64;
    localparam int SETTLE_CYCLES = 700;
    localparam int STALL_LIMIT   = 20000;
    localparam int RANDOM_ITEMS  = 1750;

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_stall;
    req_t req;
    logic res_valid;
    logic res_stall;
    res_t res;
    logic wr_en;
    logic [0:0] wr_index;
    logic [CFG_DATA_W-1:0] wr_data;

    keyframe_track_sampler u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_valid(req_valid),
        .req_stall(req_stall),
        .req      (req),
        .res_valid(res_valid),
        .res_stall(res_stall),
        .res      (res),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data)
    );

    // Shadow copy of the key table and registers.
    logic [TIME_W-1:0] key_time_tbl [NUM_SLOTS];
    longint key_val_tbl [NUM_SLOTS][4];
    logic [6:0] shadow_key_count;
    logic shadow_kind;

    res_t expected_samples[$];
    int errors;
    int load_count;
    int sample_count;
    int flagged_count;
    int quat_count;
    int burst_left;
    int idle_cycles;

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic longint unsigned magnitude(longint v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic longint round_shift(longint v, int s);
        longint unsigned m;
        m = (magnitude(v) + (64'd1 << (s - 1))) >> s;
        return (v < 0) ? -longint'(m) : longint'(m);
    endfunction

    function automatic longint unsigned floor_sqrt(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b >>= 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    // Scale a four-component vector to unit length; a zero norm gives zeros.
    function automatic void normalize4(input longint v[4], input int pre, input int post,
                                       output longint o[4]);
        longint unsigned sq;
        longint unsigned nrm;
        longint unsigned m;
        sq = 0;
        for (int k = 0; k < 4; k++)
            sq += magnitude(v[k]) * magnitude(v[k]);
        nrm = floor_sqrt(sq << pre);
        for (int k = 0; k < 4; k++)
        begin
            if (nrm == 0)
                o[k] = 0;
            else
            begin
                m = ((magnitude(v[k]) << post) + nrm / 2) / nrm;
                o[k] = (v[k] < 0) ? -longint'(m) : longint'(m);
            end
        end
    endfunction

    // Expected sample of the track at time tq.
    function automatic res_t sample_track(logic [TIME_W-1:0] tq);
        res_t e;
        int n;
        int seg;
        bit hit;
        bit flag;
        longint unsigned f;
        longint out_v[4];
        longint ka[4];
        longint kb[4];
        longint ua[4];
        longint ub[4];
        longint mix[4];
        longint dot;
        longint bk;
        n = shadow_key_count;
        if (n < 1)
            n = 1;
        if (n > NUM_SLOTS)
            n = NUM_SLOTS;
        flag = 1'b0;
        hit = 1'b0;
        f = 0;
        if (n == 1)
        begin
            for (int k = 0; k < 4; k++)
                out_v[k] = key_val_tbl[0][k];
            if (shadow_kind == KIND_VECTOR)
                out_v[3] = 0;
        end
        else
        begin
            seg = n - 2;
            for (int k = 0; k < n - 1; k++)
            begin
                if (!hit && tq < key_time_tbl[k + 1])
                begin
                    seg = k;
                    hit = 1'b1;
                end
            end
            if (!hit)
            begin
                f = 65536;
                flag = 1'b1;
            end
            else if (tq < key_time_tbl[seg])
                flag = 1'b1;
            else
                f = (longint'(tq - key_time_tbl[seg]) << 16)
                    / longint'(key_time_tbl[seg + 1] - key_time_tbl[seg]);
            if (shadow_kind == KIND_VECTOR)
            begin
                for (int k = 0; k < 3; k++)
                    out_v[k] = key_val_tbl[seg][k] + round_shift(
                        (key_val_tbl[seg + 1][k] - key_val_tbl[seg][k]) * longint'(f), 16);
                out_v[3] = 0;
            end
            else
            begin
                for (int k = 0; k < 4; k++)
                begin
                    ka[k] = key_val_tbl[seg][k];
                    kb[k] = key_val_tbl[seg + 1][k];
                end
                normalize4(ka, 14, 37, ua);
                normalize4(kb, 14, 37, ub);
                dot = 0;
                for (int k = 0; k < 4; k++)
                    dot += ua[k] * ub[k];
                for (int k = 0; k < 4; k++)
                begin
                    bk = (dot < 0) ? -ub[k] : ub[k];
                    mix[k] = round_shift(ua[k] * (65536 - longint'(f)) + bk * longint'(f), 16);
                end
                normalize4(mix, 0, 12, out_v);
            end
        end
        e.out_x = out_v[0][COMP_W-1:0];
        e.out_y = out_v[1][COMP_W-1:0];
        e.out_z = out_v[2][COMP_W-1:0];
        e.out_w = out_v[3][COMP_W-1:0];
        e.out_of_range = flag;
        return e;
    endfunction

    // Apply one accepted request to the shadow state.
    function automatic void track_request(req_t r);
        res_t e;
        if (r.operation == OP_LOAD)
        begin
            key_time_tbl[r.key_index] = r.time_req;
            key_val_tbl[r.key_index][0] = r.comp_x;
            key_val_tbl[r.key_index][1] = r.comp_y;
            key_val_tbl[r.key_index][2] = r.comp_z;
            key_val_tbl[r.key_index][3] = r.comp_w;
            load_count++;
        end
        else
        begin
            e = sample_track(r.time_req);
            expected_samples.insert(expected_samples.size(), e);
            sample_count++;
            if (e.out_of_range)
                flagged_count++;
            if (shadow_kind == KIND_QUAT)
                quat_count++;
        end
    endfunction

    // Present one request, wait for it to be taken, then maybe pause.
    task automatic send_request(req_t r);
        req <= r;
        req_valid <= 1'b1;
        do
            @(posedge clk);
        while (req_stall);
        track_request(r);
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = $urandom_range(0, 9);
            if ($urandom_range(0, 3) != 0)
            begin
                req_valid <= 1'b0;
                repeat ($urandom_range(1, 6))
                    @(posedge clk);
            end
        end
    endtask

    // Write a register once the block has drained.
    task automatic write_register(logic [0:0] idx, logic [CFG_DATA_W-1:0] val);
        req_valid <= 1'b0;
        while (expected_samples.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
        wr_en <= 1'b1;
        wr_index <= idx;
        wr_data <= val;
        @(posedge clk);
        wr_en <= 1'b0;
        if (idx == REG_KEY_COUNT)
            shadow_key_count = val;
        else
            shadow_kind = val[0];
    endtask

    function automatic req_t make_load(int slot, logic [TIME_W-1:0] tq);
        req_t r;
        r.operation = OP_LOAD;
        r.key_index = 6'(slot);
        r.time_req = tq;
        r.comp_x = 24'($urandom);
        r.comp_y = 24'($urandom);
        r.comp_z = 24'($urandom);
        r.comp_w = 24'($urandom);
        return r;
    endfunction

    function automatic req_t make_sample(logic [TIME_W-1:0] tq);
        req_t r;
        r = make_load($urandom_range(0, 63), tq);
        r.operation = OP_SAMPLE;
        return r;
    endfunction

    // Fill every slot so that no sample ever reads an unloaded key.
    task automatic test_fill_table();
        req_t r;
        for (int s = 0; s < NUM_SLOTS; s++)
        begin
            r = make_load(s, 24'(s * 256));
            if (s == 1)
            begin
                r.comp_x = 24'h7FFFFF;
                r.comp_y = 24'h800000;
                r.comp_z = 24'h000000;
                r.comp_w = 24'hFFFFFF;
            end
            send_request(r);
        end
    endtask

    // One key: the count register at zero in both modes, then at one in quaternion mode.
    task automatic test_single_key();
        write_register(REG_KEY_COUNT, 7'd0);
        send_request(make_sample(24'h000000));
        write_register(REG_TRACK_KIND, {6'h3F, KIND_QUAT});
        send_request(make_sample(24'hFFFFFF));
        write_register(REG_KEY_COUNT, 7'd1);
        send_request(make_sample(24'h123456));
    endtask

    // Edges of the time search: before the first key, on a key, between keys and at the last key.
    task automatic test_vector_edges();
        req_t r;
        write_register(REG_TRACK_KIND, {6'h00, KIND_VECTOR});
        write_register(REG_KEY_COUNT, 7'd4);
        r = make_load(0, 24'h000010);
        r.comp_x = 24'h800000;
        r.comp_y = 24'h7FFFFF;
        send_request(r);
        r = make_load(1, 24'h000010);
        r.comp_x = 24'h7FFFFF;
        r.comp_y = 24'h800000;
        send_request(r);
        send_request(make_load(2, 24'h000200));
        send_request(make_load(3, 24'hFFFFFF));
        send_request(make_sample(24'h000000));
        send_request(make_sample(24'h000010));
        send_request(make_sample(24'h000100));
        send_request(make_sample(24'h000200));
        send_request(make_sample(24'hFFFFFE));
        send_request(make_sample(24'hFFFFFF));
    endtask

    // Quaternion mode: a zero key, a sign flip, and key counts beyond and at the table size.
    task automatic test_quat_cases();
        req_t r;
        write_register(REG_TRACK_KIND, {6'h15, KIND_QUAT});
        r = make_load(1, 24'h000010);
        r.comp_x = 0;
        r.comp_y = 0;
        r.comp_z = 0;
        r.comp_w = 0;
        send_request(r);
        send_request(make_sample(24'h000100));
        r = make_load(1, 24'h000010);
        r.comp_x = -24'sd4096;
        r.comp_y = 0;
        r.comp_z = 0;
        r.comp_w = 0;
        send_request(r);
        r = make_load(2, 24'h000200);
        r.comp_x = 24'sd4096;
        r.comp_y = 24'sd100;
        r.comp_z = 0;
        r.comp_w = 0;
        send_request(r);
        send_request(make_sample(24'h000080));
        write_register(REG_KEY_COUNT, 7'd65);
        send_request(make_sample(24'h7FFFFF));
        write_register(REG_KEY_COUNT, 7'd127);
        send_request(make_sample(24'h000005));
        write_register(REG_KEY_COUNT, 7'd64);
        send_request(make_sample(24'h800000));
    endtask

    // Random phases: rebuild a short ordered track, then sample it.
    task automatic test_random_tracks();
        int sent;
        int nk;
        int step;
        int seg;
        logic [TIME_W-1:0] tq;
        logic [TIME_W-1:0] stamps [NUM_SLOTS];
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            case ($urandom_range(0, 9))
                0: nk = $urandom_range(0, 1);
                1: nk = $urandom_range(20, 64);
                2: nk = $urandom_range(65, 127);
                default: nk = $urandom_range(2, 8);
            endcase
            write_register(REG_KEY_COUNT, 7'(nk));
            write_register(REG_TRACK_KIND, 7'($urandom));
            if (nk > NUM_SLOTS)
                nk = NUM_SLOTS;
            if (nk < 1)
                nk = 1;
            // Rising key times, mostly close together, sometimes wide apart; wide steps may wrap.
            step = ($urandom_range(0, 3) == 0) ? 24'h3FFFF : 24'h3FF;
            stamps[0] = 24'($urandom_range(0, 24'h7FFFFF));
            for (int s = 1; s < nk; s++)
                stamps[s] = 24'(stamps[s - 1] + $urandom_range(1, step));
            for (int s = 0; s < nk; s++)
            begin
                send_request(make_load(s, stamps[s]));
                sent++;
            end
            repeat ($urandom_range(6, 20))
            begin
                case ($urandom_range(0, 9))
                    0: tq = 24'($urandom);
                    1: tq = stamps[$urandom_range(0, nk - 1)];
                    // Stray load: repeated, reversed or random key times.
                    2:
                    begin
                        seg = $urandom_range(0, 63);
                        send_request(make_load(seg, ($urandom_range(0, 1) == 0 && seg > 0)
                            ? key_time_tbl[seg - 1] : 24'($urandom)));
                        sent++;
                        tq = 24'(stamps[0] + $urandom_range(0, 24'hFFF));
                    end
                    default:
                    begin
                        seg = $urandom_range(0, nk - 1);
                        tq = 24'(stamps[seg] + $urandom_range(0, step));
                    end
                endcase
                send_request(make_sample(tq));
                sent++;
            end
        end
    endtask

    // Receiver: a stall pattern that picks a new character each time the low byte of its phase counter wraps.
    int stall_mode;
    int stall_phase;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_stall <= 1'b0;
            stall_mode <= 0;
            stall_phase <= 0;
        end
        else
        begin
            stall_phase <= stall_phase + 1;
            if (stall_phase[7:0] == 8'hFF)
                stall_mode <= $urandom_range(0, 3);
            case (stall_mode)
                0: res_stall <= 1'b0;
                1: res_stall <= ($urandom_range(0, 3) == 0);
                2: res_stall <= ($urandom_range(0, 7) != 0);
                default: res_stall <= stall_phase[4];
            endcase
        end
    end

    // Compare each delivered sample against the oldest prediction.
    res_t want;
    always @(posedge clk)
    begin
        if (rst_n && res_valid && !res_stall)
        begin
            if (expected_samples.size() == 0)
            begin
                $display("%0t: unexpected sample %h", $time, res);
                errors++;
            end
            else
            begin
                want = expected_samples.pop_front();
                if (res.out_x !== want.out_x)
                begin
                    $display("%0t: out_x expected %h actual %h", $time, want.out_x, res.out_x);
                    errors++;
                end
                if (res.out_y !== want.out_y)
                begin
                    $display("%0t: out_y expected %h actual %h", $time, want.out_y, res.out_y);
                    errors++;
                end
                if (res.out_z !== want.out_z)
                begin
                    $display("%0t: out_z expected %h actual %h", $time, want.out_z, res.out_z);
                    errors++;
                end
                if (res.out_w !== want.out_w)
                begin
                    $display("%0t: out_w expected %h actual %h", $time, want.out_w, res.out_w);
                    errors++;
                end
                if (res.out_of_range !== want.out_of_range)
                begin
                    $display("%0t: out_of_range expected %b actual %b", $time,
                             want.out_of_range, res.out_of_range);
                    errors++;
                end
            end
        end
    end

    // Watchdog on cycles in which neither channel moves a request or result.
    always @(posedge clk)
    begin
        if ((req_valid && !req_stall) || (res_valid && !res_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT)
        begin
            $display("tb_keyframe_track_sampler failed");
            $finish;
        end
    end

    // Main sequence.
    initial
    begin
        errors = 0;
        load_count = 0;
        sample_count = 0;
        flagged_count = 0;
        quat_count = 0;
        burst_left = 0;
        idle_cycles = 0;
        shadow_key_count = 7'd1;
        shadow_kind = KIND_VECTOR;
        rst_n = 1'b0;
        req_valid = 1'b0;
        req = '0;
        wr_en = 1'b0;
        wr_index = REG_KEY_COUNT;
        wr_data = '0;
        repeat (12)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_fill_table();
        test_single_key();
        test_vector_edges();
        test_quat_cases();
        test_random_tracks();

        req_valid <= 1'b0;
        while (expected_samples.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);

        $display("Covered %0d key loads and %0d samples (%0d quaternion, %0d out of range).",
                 load_count, sample_count, quat_count, flagged_count);
        if (errors == 0 && expected_samples.size() == 0)
            $display("tb_keyframe_track_sampler passed");
        else
            $display("tb_keyframe_track_sampler failed");
        $finish;
    end

endmodule

`default_nettype wire
